/* hw/rtl/positional_array_list_unit_defines.svh */
// ----------------------------------------------------------------------------
// Positional array list assertion macros
// Shared concurrent assertion forms, clocked on clk_i, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef POSITIONAL_ARRAY_LIST_UNIT_DEFINES_SVH
`define POSITIONAL_ARRAY_LIST_UNIT_DEFINES_SVH

// same-cycle implication
`define PAL_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define PAL_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hw/rtl/pal_pkg.sv */
// ----------------------------------------------------------------------------
// Positional array list package
// Request, status and state codes and the per-cell control bundle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package pal_pkg;

  typedef enum logic [1:0] {
    MODE_READ   = 2'd0,
    MODE_INSERT = 2'd1,
    MODE_DELETE = 2'd2,
    MODE_CLEAR  = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_BADPOS = 2'd1,
    ST_FULL   = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SEL,
    S_EXEC
  } state_e;

  // cells per read group (first read-mux stage)
  localparam int unsigned GRP_CELLS = 16;
  localparam int unsigned GRP_BITS  = 4;

  typedef struct packed {
    logic load;     // take the inserted value
    logic from_lo;  // take the lower neighbor (insert shift)
    logic from_hi;  // take the upper neighbor (delete shift)
  } cell_ctl_t;

endpackage

`default_nettype wire

/* hw/rtl/pal_cell.sv */
// ----------------------------------------------------------------------------
// Positional array list cell
// One list slot; loads a new value or takes a neighbor's word on a shift.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pal_cell #(
  parameter int unsigned WORD_BITS = 32
) (
  input  wire logic                   clk_i,
  input  wire pal_pkg::cell_ctl_t     ctl_i,
  input  wire logic [WORD_BITS-1:0]   lo_i,
  input  wire logic [WORD_BITS-1:0]   hi_i,
  input  wire logic [WORD_BITS-1:0]   val_i,
  output logic [WORD_BITS-1:0]        q_o
);
  import pal_pkg::*;

  logic [WORD_BITS-1:0] word_q;
  logic [WORD_BITS-1:0] word_d;

  always_comb begin
    word_d = word_q;
    if (ctl_i.load) begin
      word_d = val_i;
    end else if (ctl_i.from_lo) begin
      word_d = lo_i;
    end else if (ctl_i.from_hi) begin
      word_d = hi_i;
    end
  end

  always_ff @(posedge clk_i) begin
    word_q <= word_d;
  end

  assign q_o = word_q;

endmodule

`default_nettype wire

/* hw/rtl/positional_array_list_unit.sv */
// ----------------------------------------------------------------------------
// Positional array list unit
// Ordered list of signed words with read, insert, delete and clear by
// 1-based position, kept in a row of shifting cells.
// ----------------------------------------------------------------------------
// Each request passes through the states S_IDLE, which accepts the item, S_SEL,
// in which the first read-mux stage picks a word out of every group of 16 cells,
// and S_EXEC, in which the group word is selected, every cell shifts toward its
// neighbor at once for an insert or delete, and the result is registered.
// The next item is accepted once S_EXEC returns to S_IDLE, also while the
// previous result still waits; a held result stalls S_EXEC of the next item.
// No clearing pass is needed after reset.
`timescale 1ns / 1ps
`default_nettype none

`include "positional_array_list_unit_defines.svh"

module positional_array_list_unit #(
  parameter int unsigned CAPACITY  = 128,
  parameter int unsigned WORD_BITS = 32
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire pal_pkg::mode_e                mode_i,
  input  wire logic [7:0]                    position_i,
  input  wire logic signed [WORD_BITS-1:0]   value_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output pal_pkg::status_e                   status_o,
  output logic signed [WORD_BITS-1:0]        data_o,
  output logic [7:0]                         count_o
);
  import pal_pkg::*;

  localparam int unsigned FW  = $clog2(CAPACITY + 1);
  localparam int unsigned CW  = (FW > 8) ? FW : 8;
  localparam int unsigned AW  = ($clog2(CAPACITY) < GRP_BITS) ? GRP_BITS : $clog2(CAPACITY);
  localparam int unsigned NG  = 1 << (AW - GRP_BITS);
  localparam logic [CW-1:0] CAP_CW = CW'(CAPACITY);

  state_e state_q, state_d;
  logic   in_ready, sel_en, exec_go;

  mode_e                req_mode_q;
  logic [7:0]           req_pos_q;
  logic [WORD_BITS-1:0] req_val_q;
  logic [FW-1:0]        fill_q, fill_d;

  logic                 out_valid_q;
  status_e              status_q, status_d;
  logic [WORD_BITS-1:0] data_q, data_d;
  logic [7:0]           count_q;

  logic [CW-1:0] pos_cw, fill_cw, idx_cw, fill_nx_cw;
  logic [AW-1:0] idx_a;
  logic          rd_ok, ins_pos_ok, full, do_ins, do_del;

  logic [WORD_BITS-1:0] cell_q    [CAPACITY];
  cell_ctl_t            cell_ctl  [CAPACITY];
  logic [WORD_BITS-1:0] cell_grid [NG][GRP_CELLS];
  logic [WORD_BITS-1:0] grp_q     [NG];
  logic [WORD_BITS-1:0] rd_word;

  // control FSM
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) state_d = S_SEL;
      end
      S_SEL:  state_d = S_EXEC;
      S_EXEC: begin
        if (exec_go) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    sel_en   = 1'b0;
    exec_go  = 1'b0;
    unique case (state_q)
      S_IDLE:  in_ready = 1'b1;
      S_SEL:   sel_en   = 1'b1;
      S_EXEC:  exec_go  = !out_valid_q || out_ready_i;
      default: in_ready = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready) begin
      req_mode_q <= mode_i;
      req_pos_q  <= position_i;
      req_val_q  <= value_i;
    end
  end

  // request decode
  assign pos_cw     = CW'(req_pos_q);
  assign fill_cw    = CW'(fill_q);
  assign idx_cw     = pos_cw - CW'(1);
  assign idx_a      = idx_cw[AW-1:0];
  assign rd_ok      = (req_pos_q != 8'd0) && (pos_cw <= fill_cw);
  assign ins_pos_ok = (req_pos_q != 8'd0) && (idx_cw <= fill_cw);
  assign full       = (fill_cw == CAP_CW);
  assign do_ins     = exec_go && (req_mode_q == MODE_INSERT) && ins_pos_ok && !full;
  assign do_del     = exec_go && (req_mode_q == MODE_DELETE) && rd_ok;

  // cell row
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    localparam logic [CW-1:0] CI = CW'(i);
    logic [WORD_BITS-1:0] lo_w, hi_w;

    if (i == 0) begin : g_first
      assign lo_w = '0;
    end else begin : g_lo
      assign lo_w = cell_q[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign hi_w = '0;
    end else begin : g_hi
      assign hi_w = cell_q[i+1];
    end

    assign cell_ctl[i].load    = do_ins && (CI == idx_cw);
    assign cell_ctl[i].from_lo = do_ins && (CI > idx_cw) && (CI <= fill_cw);
    assign cell_ctl[i].from_hi = do_del && (CI >= idx_cw) && ((CI + CW'(1)) < fill_cw);

    pal_cell #(
      .WORD_BITS (WORD_BITS)
    ) u_cell (
      .clk_i  (clk_i),
      .ctl_i  (cell_ctl[i]),
      .lo_i   (lo_w),
      .hi_i   (hi_w),
      .val_i  (req_val_q),
      .q_o    (cell_q[i])
    );
  end

  // two-stage read mux
  for (genvar g = 0; g < NG; g++) begin : g_grp
    for (genvar j = 0; j < GRP_CELLS; j++) begin : g_slot
      if (g * GRP_CELLS + j < CAPACITY) begin : g_real
        assign cell_grid[g][j] = cell_q[g*GRP_CELLS+j];
      end else begin : g_pad
        assign cell_grid[g][j] = '0;
      end
    end

    always_ff @(posedge clk_i) begin
      if (sel_en) begin
        grp_q[g] <= cell_grid[g][idx_a[GRP_BITS-1:0]];
      end
    end
  end

  if (NG == 1) begin : g_one_grp
    assign rd_word = grp_q[0];
  end else begin : g_many_grp
    assign rd_word = grp_q[idx_a[AW-1:GRP_BITS]];
  end

  // result and fill update
  always_comb begin
    status_d   = ST_OK;
    data_d     = '0;
    fill_nx_cw = fill_cw;
    unique case (req_mode_q)
      MODE_READ: begin
        if (rd_ok) data_d = rd_word;
        else       status_d = ST_BADPOS;
      end
      MODE_INSERT: begin
        if (!ins_pos_ok) begin
          status_d = ST_BADPOS;
        end else if (full) begin
          status_d = ST_FULL;
        end else begin
          fill_nx_cw = fill_cw + CW'(1);
        end
      end
      MODE_DELETE: begin
        if (rd_ok) begin
          data_d     = rd_word;
          fill_nx_cw = fill_cw - CW'(1);
        end else begin
          status_d = ST_BADPOS;
        end
      end
      MODE_CLEAR: fill_nx_cw = '0;
      default:    status_d = ST_OK;
    endcase
  end

  assign fill_d = exec_go ? fill_nx_cw[FW-1:0] : fill_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      fill_q <= fill_d;
      if (exec_go) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (exec_go) begin
      status_q <= status_d;
      data_q   <= data_d;
      count_q  <= fill_nx_cw[7:0];
    end
  end

  assign in_ready_o  = in_ready;
  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;
  assign data_o      = data_q;
  assign count_o     = count_q;

  `PAL_ASSERT_NOW(a_fill_bound, 1'b1, fill_cw <= CAP_CW, "fill exceeds capacity")
  `PAL_ASSERT_NEXT(a_ins_grow, do_ins, fill_q == $past(fill_q) + FW'(1), "fill did not grow")
  `PAL_ASSERT_NEXT(a_exec_out, exec_go, out_valid_q && (state_q == S_IDLE), "result not posted")
  `PAL_ASSERT_NOW(a_full_st, out_valid_q && (status_q == ST_FULL), full, "full status, not full")

endmodule

`default_nettype wire

/* verif/tb.sv */
// ----------------------------------------------------------------------------
// Positional array list unit testbench
// Drives read, insert, delete and clear requests over valid/ready with random
// gaps and receiver stalls. A short table of directed requests comes first,
// then a fill to capacity, then random phases that grow, shrink and churn
// the list. Each result is checked against the table or an in-order prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
  import pal_pkg::*;

  localparam int unsigned LIST_DEPTH = 128;
  localparam int unsigned WORD_W     = 32;
  localparam int unsigned RAND_ITEMS = 1300;

  typedef struct {
    status_e                  status;
    logic signed [WORD_W-1:0] data;
    logic [7:0]               count;
  } result_t;

  typedef struct {
    mode_e                    mode;
    logic [7:0]               pos;
    logic signed [WORD_W-1:0] value;
    bit                       typed;
    result_t                  res;
  } dir_row_t;

  typedef enum int {PH_GROW, PH_SHRINK, PH_MIX} phase_e;

  logic                     clk_i;
  logic                     rst_ni;
  logic                     in_valid_i;
  logic                     in_ready_o;
  mode_e                    mode_i;
  logic [7:0]               position_i;
  logic signed [WORD_W-1:0] value_i;
  logic                     out_valid_o;
  logic                     out_ready_i;
  status_e                  status_o;
  logic signed [WORD_W-1:0] data_o;
  logic [7:0]               count_o;

  logic signed [WORD_W-1:0] list_mem [LIST_DEPTH];
  int                       list_len;
  result_t                  pending_q [$];
  int                       err_cnt;
  int                       got_cnt;

  positional_array_list_unit #(
    .CAPACITY  (LIST_DEPTH),
    .WORD_BITS (WORD_W)
  ) i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .mode_i      (mode_i),
    .position_i  (position_i),
    .value_i     (value_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_o    (status_o),
    .data_o      (data_o),
    .count_o     (count_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("tb: FAIL");
    $finish;
  end

  function automatic result_t list_step(mode_e m, logic [7:0] p, logic signed [WORD_W-1:0] v);
    result_t r;
    int      pi;
    pi = int'(p);
    r.status = ST_OK;
    r.data   = '0;
    case (m)
      MODE_READ: begin
        if (pi < 1 || pi > list_len) r.status = ST_BADPOS;
        else r.data = list_mem[pi-1];
      end
      MODE_INSERT: begin
        if (pi < 1 || pi > list_len + 1) begin
          r.status = ST_BADPOS;
        end else if (list_len >= LIST_DEPTH) begin
          r.status = ST_FULL;
        end else begin
          for (int k = list_len; k > pi - 1; k--) list_mem[k] = list_mem[k-1];
          list_mem[pi-1] = v;
          list_len++;
        end
      end
      MODE_DELETE: begin
        if (pi < 1 || pi > list_len) begin
          r.status = ST_BADPOS;
        end else begin
          r.data = list_mem[pi-1];
          for (int k = pi - 1; k + 1 < list_len; k++) list_mem[k] = list_mem[k+1];
          list_len--;
        end
      end
      default: list_len = 0;
    endcase
    r.count = list_len[7:0];
    return r;
  endfunction

  function automatic int idle_len();
    int r;
    r = $urandom_range(99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic mode_e pick_mode(phase_e ph);
    int r;
    r = $urandom_range(99);
    case (ph)
      PH_GROW: begin
        if (r < 75) return MODE_INSERT;
        if (r < 88) return MODE_READ;
        if (r < 98) return MODE_DELETE;
        return MODE_CLEAR;
      end
      PH_SHRINK: begin
        if (r < 55) return MODE_DELETE;
        if (r < 75) return MODE_READ;
        if (r < 97) return MODE_INSERT;
        return MODE_CLEAR;
      end
      default: begin
        if (r < 30) return MODE_READ;
        if (r < 62) return MODE_INSERT;
        if (r < 96) return MODE_DELETE;
        return MODE_CLEAR;
      end
    endcase
  endfunction

  // mostly legal positions, weighted toward the ends, with some out of range
  function automatic logic [7:0] pick_pos(mode_e m);
    int lim;
    int r;
    lim = (m == MODE_INSERT) ? list_len + 1 : list_len;
    r = $urandom_range(99);
    if (r < 6) return 8'd0;
    if (r < 14) return 8'($urandom_range(255));
    if (r < 20) return 8'(lim + 1);
    if (lim < 1) return 8'($urandom_range(1));
    if (r < 30) return 8'd1;
    if (r < 40) return 8'(lim);
    return 8'($urandom_range(1, lim));
  endfunction

  function automatic logic signed [WORD_W-1:0] pick_value();
    int r;
    r = $urandom_range(99);
    if (r < 3) return {1'b0, {(WORD_W-1){1'b1}}};
    if (r < 6) return {1'b1, {(WORD_W-1){1'b0}}};
    if (r < 8) return '1;
    if (r < 10) return '0;
    return $urandom;
  endfunction

  task automatic send_item(mode_e m, logic [7:0] p, logic signed [WORD_W-1:0] v, bit typed,
                           result_t typed_res, int gap);
    result_t r;
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    mode_i     <= m;
    position_i <= p;
    value_i    <= v;
    do @(posedge clk_i); while (!in_ready_o);
    r = list_step(m, p, v);
    pending_q.push_back(typed ? typed_res : r);
    repeat (gap) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      mode_i     <= mode_e'($urandom_range(3));
      position_i <= 8'($urandom_range(255));
      value_i    <= $urandom;
    end
  endtask

  always @(posedge clk_i) begin
    result_t e;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got_cnt++;
      if (pending_q.size() == 0) begin
        $error("unexpected result: status=%0d data=%0d count=%0d", status_o, data_o, count_o);
        err_cnt++;
      end else begin
        e = pending_q.pop_front();
        if (status_o !== e.status) begin
          $error("status: expected %0d, got %0d", e.status, status_o);
          err_cnt++;
        end
        if (data_o !== e.data) begin
          $error("data: expected %0d, got %0d", e.data, data_o);
          err_cnt++;
        end
        if (count_o !== e.count) begin
          $error("count: expected %0d, got %0d", e.count, count_o);
          err_cnt++;
        end
      end
    end
  end

  // receiver: random stalls, quiet stretches, and one long hold-off
  initial begin
    int  hold;
    int  cyc;
    bit  quiet;
    bit  pressed;
    out_ready_i = 1'b0;
    hold = 0;
    cyc = 0;
    quiet = 1'b0;
    pressed = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      cyc++;
      if (cyc % 128 == 0) quiet = ($urandom_range(2) == 0);
      if (hold > 0) begin
        out_ready_i <= 1'b0;
        hold--;
      end else if (!pressed && got_cnt >= 300) begin
        pressed = 1'b1;
        out_ready_i <= 1'b0;
        hold = 400;
      end else begin
        hold = quiet ? 0 : idle_len();
        out_ready_i <= (hold == 0);
        if (hold > 0) hold--;
      end
    end
  end

  initial begin
    dir_row_t dir_tab [24];
    phase_e   ph;
    int       ph_len;
    int       sent;
    bit       burst;
    mode_e    m;
    result_t  none;

    localparam logic signed [WORD_W-1:0] W_MAX = {1'b0, {(WORD_W-1){1'b1}}};
    localparam logic signed [WORD_W-1:0] W_MIN = {1'b1, {(WORD_W-1){1'b0}}};

    rst_ni     = 1'b0;
    in_valid_i = 1'b0;
    mode_i     = MODE_READ;
    position_i = '0;
    value_i    = '0;
    list_len   = 0;
    err_cnt    = 0;
    got_cnt    = 0;
    none       = '{ST_OK, '0, '0};

    dir_tab = '{
      '{MODE_READ,   8'd1,   32'sd0,        1'b1, '{ST_BADPOS, 32'sd0, 8'd0}},
      '{MODE_DELETE, 8'd1,   32'sd0,        1'b1, '{ST_BADPOS, 32'sd0, 8'd0}},
      '{MODE_INSERT, 8'd0,   32'sd5,        1'b1, '{ST_BADPOS, 32'sd0, 8'd0}},
      '{MODE_INSERT, 8'd2,   32'sd5,        1'b1, '{ST_BADPOS, 32'sd0, 8'd0}},
      '{MODE_INSERT, 8'd1,   W_MAX,         1'b1, '{ST_OK,     32'sd0, 8'd1}},
      '{MODE_INSERT, 8'd1,   W_MIN,         1'b1, '{ST_OK,     32'sd0, 8'd2}},
      '{MODE_INSERT, 8'd3,   -32'sd1,       1'b1, '{ST_OK,     32'sd0, 8'd3}},
      '{MODE_INSERT, 8'd2,   32'sd0,        1'b1, '{ST_OK,     32'sd0, 8'd4}},
      '{MODE_INSERT, 8'd6,   32'sd1,        1'b1, '{ST_BADPOS, 32'sd0, 8'd4}},
      '{MODE_READ,   8'd1,   32'sd0,        1'b1, '{ST_OK,     W_MIN,  8'd4}},
      '{MODE_READ,   8'd4,   32'sd0,        1'b1, '{ST_OK,     -32'sd1, 8'd4}},
      '{MODE_READ,   8'd3,   32'sd0,        1'b0, none},
      '{MODE_READ,   8'd5,   32'sd0,        1'b1, '{ST_BADPOS, 32'sd0, 8'd4}},
      '{MODE_READ,   8'd255, 32'sd0,        1'b1, '{ST_BADPOS, 32'sd0, 8'd4}},
      '{MODE_READ,   8'd0,   32'sd0,        1'b1, '{ST_BADPOS, 32'sd0, 8'd4}},
      '{MODE_DELETE, 8'd2,   32'sd0,        1'b0, none},
      '{MODE_DELETE, 8'd3,   32'sd0,        1'b0, none},
      '{MODE_DELETE, 8'd0,   32'sd0,        1'b1, '{ST_BADPOS, 32'sd0, 8'd2}},
      '{MODE_DELETE, 8'd3,   32'sd0,        1'b1, '{ST_BADPOS, 32'sd0, 8'd2}},
      '{MODE_INSERT, 8'd3,   32'h5A5A5A5A,  1'b0, none},
      '{MODE_DELETE, 8'd1,   32'sd0,        1'b0, none},
      '{MODE_CLEAR,  8'd200, 32'h12345678,  1'b1, '{ST_OK,     32'sd0, 8'd0}},
      '{MODE_READ,   8'd1,   32'sd0,        1'b1, '{ST_BADPOS, 32'sd0, 8'd0}},
      '{MODE_INSERT, 8'd1,   32'hA5A5A5A5,  1'b1, '{ST_OK,     32'sd0, 8'd1}}
    };

    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (dir_tab[i]) begin
      send_item(dir_tab[i].mode, dir_tab[i].pos, dir_tab[i].value, dir_tab[i].typed,
                dir_tab[i].res, idle_len());
    end

    // grow to capacity so the full-list case is reached early
    while (list_len < LIST_DEPTH) begin
      m = ($urandom_range(9) < 8) ? MODE_INSERT : MODE_READ;
      send_item(m, pick_pos(m), pick_value(), 1'b0, none, idle_len());
    end

    sent = 0;
    while (sent < RAND_ITEMS) begin
      ph     = phase_e'($urandom_range(2));
      ph_len = $urandom_range(40, 200);
      burst  = ($urandom_range(3) == 0);
      for (int n = 0; n < ph_len && sent < RAND_ITEMS; n++) begin
        m = pick_mode(ph);
        send_item(m, pick_pos(m), pick_value(), 1'b0, none, burst ? 0 : idle_len());
        sent++;
      end
    end

    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);

    if (err_cnt == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule
